/* rtl/sfmr_pkg.sv */
// Package for the stepper floor move ramp block: register widths, reset values,
// register indexes and the ramp limits.
// It depends on nothing else.
package sfmr_pkg;

  // Width of the period registers and the tick counter.
  localparam int unsigned PERIOD_W = 10;
  // Width of the steps per floor register.
  localparam int unsigned SPF_W = 12;
  // Width of the brake distance register.
  localparam int unsigned BRAKE_W = 10;
  // Configuration port: data as wide as the widest register, four registers.
  localparam int unsigned CFG_W = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // Default number of floor index bits.
  localparam int unsigned FLOOR_BITS_DEF = 6;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_FLOOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_DISTANCE = 2'd3;

  // Reset values of the registers.
  localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 10'd120;
  localparam logic [PERIOD_W-1:0] TOP_PERIOD_RST = 10'd8;
  localparam logic [SPF_W-1:0] STEPS_PER_FLOOR_RST = 12'd601;
  localparam logic [BRAKE_W-1:0] BRAKE_DISTANCE_RST = 10'd100;

  // The half period saturates here while braking.
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 10'd1023;

  // Command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

endpackage

/* rtl/stepper_floor_move_ramp_top.sv */
// Top level of the stepper floor move ramp block: input register, move and ramp
// logic, and the result register with its handshake.
// It depends on sfmr_pkg.

// The block drives a lift's stepper motor from a stream of words, each of which
// is either one tick of the timebase or a command to move to a target floor. A
// move sets the step count to the floor difference times steps_per_floor and the
// direction from its sign, and it starts the half period at start_period. Every
// motor pulse has a low phase and then a high phase, each lasting half_period
// ticks (one tick when the half period is zero). After each pulse the half period
// falls by one towards top_period while more than brake_distance steps remained
// before that pulse, and otherwise it rises by one, saturating at 1023. A move
// given while a move is in progress is dropped and counts as no tick. When the
// last step is done the floor position takes the target, and move_done is high on
// that word. Each accepted word gives exactly one result word. Rate: one word is
// accepted in every cycle while the output side is not stalled; a result is
// presented from the result register after its word has waited in the input
// register, and the move and ramp logic between the input and result
// registers closes the whole state loop within the same cycle, so that the next
// tick sees the updated counters at once. Configuration should be written only
// while the block is idle; there is no clearing pass after reset.
module stepper_floor_move_ramp_top #(
  parameter int unsigned FLOOR_BITS = sfmr_pkg::FLOOR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [sfmr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfmr_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [FLOOR_BITS-1:0]           target_floor_i,
  // Output channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            step_line_o,
  output logic                            dir_line_o,
  output logic                            busy_res_o,
  output logic                            move_done_o,
  output logic [FLOOR_BITS-1:0]           floor_position_o
);
  import sfmr_pkg::*;

  // The step count holds a floor difference times the steps per floor.
  localparam int unsigned STEP_W = FLOOR_BITS + SPF_W;

  // Configuration registers.
  logic [PERIOD_W-1:0] start_period_q;
  logic [PERIOD_W-1:0] top_period_q;
  logic [SPF_W-1:0]    steps_per_floor_q;
  logic [BRAKE_W-1:0]  brake_distance_q;

  // Input register.
  logic                  in_valid_q;
  logic                  cmd_q;
  logic [FLOOR_BITS-1:0] target_q;

  // Move state.
  logic [FLOOR_BITS-1:0] cur_floor_q, cur_floor_d;
  logic [FLOOR_BITS-1:0] goal_floor_q, goal_floor_d;
  logic [STEP_W-1:0]     total_steps_q, total_steps_d;
  logic [STEP_W-1:0]     steps_done_q, steps_done_d;
  logic [PERIOD_W-1:0]   half_period_q, half_period_d;
  logic [PERIOD_W-1:0]   tick_count_q, tick_count_d;
  logic                  high_phase_q, high_phase_d;
  logic                  moving_up_q, moving_up_d;
  logic                  moving_q, moving_d;
  logic                  done_d;

  // Result register.
  logic                  out_valid_q;
  logic                  step_line_q;
  logic                  dir_line_q;
  logic                  busy_res_q;
  logic                  move_done_q;
  logic [FLOOR_BITS-1:0] floor_pos_q;

  // Handshake and datapath helpers.
  logic                  out_free;
  logic                  fire;
  logic                  target_above;
  logic [FLOOR_BITS-1:0] floor_dist;
  logic [STEP_W-1:0]     move_steps;
  logic [STEP_W-1:0]     remaining;
  logic [STEP_W-1:0]     steps_next;
  logic [PERIOD_W-1:0]   tick_next;

  // The result register can take a new word when it is empty or being emptied.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The word in the input register is processed when the result can be stored.
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Configuration registers are written directly; no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_period_q    <= START_PERIOD_RST;
      top_period_q      <= TOP_PERIOD_RST;
      steps_per_floor_q <= STEPS_PER_FLOOR_RST;
      brake_distance_q  <= BRAKE_DISTANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_PERIOD:    start_period_q    <= cfg_wdata_i[PERIOD_W-1:0];
        REG_TOP_PERIOD:      top_period_q      <= cfg_wdata_i[PERIOD_W-1:0];
        REG_STEPS_PER_FLOOR: steps_per_floor_q <= cfg_wdata_i[SPF_W-1:0];
        REG_BRAKE_DISTANCE:  brake_distance_q  <= cfg_wdata_i[BRAKE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it is not holding a stalled word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      cmd_q    <= cmd_i;
      target_q <= target_floor_i;
    end
  end

  // Floor difference and the resulting step count of a new move. The product is
  // at most FLOOR_BITS by twelve bits.
  assign target_above = target_q > cur_floor_q;
  assign floor_dist   = target_above ? (target_q - cur_floor_q) : (cur_floor_q - target_q);
  assign move_steps   = STEP_W'(floor_dist) * STEP_W'(steps_per_floor_q);

  // Steps still to go before the current pulse completes, used for the ramp.
  assign remaining  = total_steps_q - steps_done_q;
  assign steps_next = steps_done_q + STEP_W'(1);
  assign tick_next  = tick_count_q + PERIOD_W'(1);

  always_comb begin
    cur_floor_d   = cur_floor_q;
    goal_floor_d  = goal_floor_q;
    total_steps_d = total_steps_q;
    steps_done_d  = steps_done_q;
    half_period_d = half_period_q;
    tick_count_d  = tick_count_q;
    high_phase_d  = high_phase_q;
    moving_up_d   = moving_up_q;
    moving_d      = moving_q;
    done_d        = 1'b0;
    if (cmd_q == CMD_MOVE) begin
      // A move is only taken while idle.
      if (!moving_q) begin
        moving_up_d   = target_above;
        goal_floor_d  = target_q;
        total_steps_d = move_steps;
        steps_done_d  = '0;
        half_period_d = start_period_q;
        tick_count_d  = '0;
        high_phase_d  = 1'b0;
        if (move_steps == '0) begin
          // Nothing to travel: the move finishes on the command word itself.
          cur_floor_d = target_q;
          done_d      = 1'b1;
        end else begin
          moving_d = 1'b1;
        end
      end
    end else if (moving_q) begin
      tick_count_d = tick_next;
      if (tick_next >= half_period_q) begin
        tick_count_d = '0;
        if (!high_phase_q) begin
          high_phase_d = 1'b1;
        end else begin
          high_phase_d = 1'b0;
          if (remaining > STEP_W'(brake_distance_q)) begin
            if (half_period_q > top_period_q) begin
              half_period_d = half_period_q - PERIOD_W'(1);
            end
          end else if (half_period_q < PERIOD_MAX) begin
            half_period_d = half_period_q + PERIOD_W'(1);
          end
          steps_done_d = steps_next;
          if (steps_next >= total_steps_q) begin
            moving_d    = 1'b0;
            cur_floor_d = goal_floor_q;
            done_d      = 1'b1;
          end
        end
      end
    end
  end

  // Move state advances once for every word that is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_floor_q   <= '0;
      goal_floor_q  <= '0;
      total_steps_q <= '0;
      steps_done_q  <= '0;
      half_period_q <= START_PERIOD_RST;
      tick_count_q  <= '0;
      high_phase_q  <= 1'b0;
      moving_up_q   <= 1'b0;
      moving_q      <= 1'b0;
    end else if (fire) begin
      cur_floor_q   <= cur_floor_d;
      goal_floor_q  <= goal_floor_d;
      total_steps_q <= total_steps_d;
      steps_done_q  <= steps_done_d;
      half_period_q <= half_period_d;
      tick_count_q  <= tick_count_d;
      high_phase_q  <= high_phase_d;
      moving_up_q   <= moving_up_d;
      moving_q      <= moving_d;
    end
  end

  // Result register: valid flag with reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      // The pulse line follows the high phase; the direction line is only
      // raised inside a pulse of an upward move.
      step_line_q <= moving_d && high_phase_d;
      dir_line_q  <= moving_d && high_phase_d && moving_up_d;
      busy_res_q  <= moving_d;
      move_done_q <= done_d;
      floor_pos_q <= cur_floor_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_line_o      = step_line_q;
  assign dir_line_o       = dir_line_q;
  assign busy_res_o       = busy_res_q;
  assign move_done_o      = move_done_q;
  assign floor_position_o = floor_pos_q;

`ifndef NO_ASSERTIONS
  // A pulse is only ever shown while a move is in progress.
  a_step_needs_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && step_line_q |-> busy_res_q)
    else $error("step pulse reported without a move in progress");

  // A move that finishes must not still be reported as busy.
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && move_done_q |-> !busy_res_q)
    else $error("move reported as done and busy on the same word");

  // While moving, the step counter stays below the step count of the move.
  a_steps_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (steps_done_q < total_steps_q))
    else $error("step counter reached the step count while still moving");

  // The move state only changes when a word is processed.
  a_state_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(moving_q) && $stable(cur_floor_q) && $stable(steps_done_q))
    else $error("move state changed without a word being processed");
`endif

endmodule

/* tb/sv/floor_move_sb_pkg.sv */
// Scoreboard package for the stepper floor move ramp testbench: the result word
// type and a class that predicts each result and checks what the block returns.
// It depends on sfmr_pkg for the register widths, indexes and command codes.
`timescale 1ns / 100ps

package floor_move_sb_pkg;
  import sfmr_pkg::*;

  localparam int unsigned FLOOR_W = FLOOR_BITS_DEF;
  localparam int unsigned STEPS_W = 18;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct packed {
    logic               step_line;
    logic               dir_line;
    logic               busy;
    logic               move_done;
    logic [FLOOR_W-1:0] floor_pos;
  } move_result_t;

  class floor_move_scoreboard;
    logic [PERIOD_W-1:0] start_period;
    logic [PERIOD_W-1:0] top_period;
    logic [SPF_W-1:0]    steps_per_floor;
    logic [BRAKE_W-1:0]  brake_distance;

    logic [FLOOR_W-1:0]  cur_floor;
    logic [FLOOR_W-1:0]  goal_floor;
    logic [STEPS_W-1:0]  total_steps;
    logic [STEPS_W-1:0]  steps_done;
    logic [PERIOD_W-1:0] half_period;
    logic [PERIOD_W-1:0] tick_count;
    bit                  high_phase;
    bit                  moving_up;
    bit                  moving;

    move_result_t        expected_q[$];
    int unsigned         errors;

    function new();
      start_period    = START_PERIOD_RST;
      top_period      = TOP_PERIOD_RST;
      steps_per_floor = STEPS_PER_FLOOR_RST;
      brake_distance  = BRAKE_DISTANCE_RST;
      cur_floor       = '0;
      goal_floor      = '0;
      total_steps     = '0;
      steps_done      = '0;
      half_period     = START_PERIOD_RST;
      tick_count      = '0;
      high_phase      = 1'b0;
      moving_up       = 1'b0;
      moving          = 1'b0;
      errors          = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_START_PERIOD:    start_period = val[PERIOD_W-1:0];
        REG_TOP_PERIOD:      top_period = val[PERIOD_W-1:0];
        REG_STEPS_PER_FLOOR: steps_per_floor = val[SPF_W-1:0];
        REG_BRAKE_DISTANCE:  brake_distance = val[BRAKE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advances the predicted state by one accepted word and queues its result.
    function void note_input(logic cmd, logic [FLOOR_W-1:0] target);
      move_result_t       res;
      logic [FLOOR_W-1:0] floor_diff;
      logic [STEPS_W-1:0] remaining;
      bit                 done;
      done = 1'b0;
      if (cmd == CMD_MOVE) begin
        if (!moving) begin
          if (target > cur_floor) begin
            floor_diff = target - cur_floor;
            moving_up = 1'b1;
          end else begin
            floor_diff = cur_floor - target;
            moving_up = 1'b0;
          end
          goal_floor  = target;
          total_steps = STEPS_W'(floor_diff) * STEPS_W'(steps_per_floor);
          steps_done  = '0;
          half_period = start_period;
          tick_count  = '0;
          high_phase  = 1'b0;
          if (total_steps == '0) begin
            cur_floor = goal_floor;
            done = 1'b1;
          end else begin
            moving = 1'b1;
          end
        end
      end else if (moving) begin
        tick_count = tick_count + 1'b1;
        if (tick_count >= half_period) begin
          tick_count = '0;
          if (!high_phase) begin
            high_phase = 1'b1;
          end else begin
            remaining  = total_steps - steps_done;
            high_phase = 1'b0;
            if (remaining > brake_distance) begin
              if (half_period > top_period) half_period = half_period - 1'b1;
            end else if (half_period < PERIOD_MAX) begin
              half_period = half_period + 1'b1;
            end
            steps_done = steps_done + 1'b1;
            if (steps_done >= total_steps) begin
              moving = 1'b0;
              cur_floor = goal_floor;
              done = 1'b1;
            end
          end
        end
      end
      res.step_line = moving && high_phase;
      res.dir_line  = moving && high_phase && moving_up;
      res.busy      = moving;
      res.move_done = done;
      res.floor_pos = cur_floor;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic step_line, logic dir_line, logic busy,
                               logic move_done, logic [FLOOR_W-1:0] floor_pos);
      move_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result word with none expected, expected none, actual %0h",
                   $time, {step_line, dir_line, busy, move_done, floor_pos});
        return;
      end
      want = expected_q.pop_front();
      compare_field("step_line", want.step_line, step_line);
      compare_field("dir_line", want.dir_line, dir_line);
      compare_field("busy_res", want.busy, busy);
      compare_field("move_done", want.move_done, move_done);
      compare_field("floor_position", want.floor_pos, floor_pos);
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
// Top of the stepper floor move ramp testbench: clock, reset, word drivers for
// the input channel and the configuration port, output stall and result checking.
// It depends on sfmr_pkg, floor_move_sb_pkg and the block stepper_floor_move_ramp_top.
`timescale 1ns / 100ps

module tb_top;
  import sfmr_pkg::*;
  import floor_move_sb_pkg::*;

  // A generous bound on the whole run; the slowest legal run stays far below it.
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 cmd_d = CMD_TICK;
  logic [FLOOR_W-1:0]   target_d = '0;
  logic                 out_stall = 1'b0;

  logic                 in_stall;
  logic                 out_valid;
  logic                 step_line;
  logic                 dir_line;
  logic                 busy;
  logic                 move_done;
  logic [FLOOR_W-1:0]   floor_pos;

  floor_move_scoreboard sb;

  // Idling controls: gaps on the sending side are decided by the stimulus
  // process itself, stall bursts on the receiving side by their own block.
  bit                   send_gaps = 1'b0;
  logic                 stall_en = 1'b0;
  int unsigned          stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stepper_floor_move_ramp_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd_d),
    .target_floor_i  (target_d),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .step_line_o     (step_line),
    .dir_line_o      (dir_line),
    .busy_res_o      (busy),
    .move_done_o     (move_done),
    .floor_position_o(floor_pos)
  );

  // Receiving side. Bursts of stall start at random while stalling is on; between
  // bursts, and once a running burst ends with stalling off, result words flow freely.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_en && $urandom_range(5, 0) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(4, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result word taken at this edge is checked against the oldest
  // prediction. The values read here are the ones settled before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_result(step_line, dir_line, busy, move_done, floor_pos);
  end

  // Watchdog: a hung handshake or a block that stops answering ends the run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_top: FAIL");
    $finish;
  end

  // Offers one word and waits for the edge that takes it. The task is always
  // entered at a rising edge, so valid is changed at most once per time step.
  // An optional gap with valid low can come before the word is offered.
  task automatic send_word(logic cmd, logic [FLOOR_W-1:0] target);
    if (send_gaps && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_d    <= cmd;
    target_d <= target;
    @(posedge clk_i);
    while (in_stall !== 1'b0) @(posedge clk_i);
    sb.note_input(cmd, target);
  endtask

  // Feeds ticks until the predicted move has finished, so that the block is
  // known to be at rest before the registers are touched again.
  task automatic drain_move();
    while (sb.moving) send_word(CMD_TICK, FLOOR_W'($urandom_range(63, 0)));
  endtask

  // Registers are written only with nothing in flight: every predicted result
  // must have come back, and a further wait covers the input and result registers.
  task automatic set_config(logic [CFG_W-1:0] sp, logic [CFG_W-1:0] tp,
                            logic [CFG_W-1:0] spf, logic [CFG_W-1:0] bd);
    logic [CFG_W-1:0] vals [4];
    vals[REG_START_PERIOD]    = sp;
    vals[REG_TOP_PERIOD]      = tp;
    vals[REG_STEPS_PER_FLOOR] = spf;
    vals[REG_BRAKE_DISTANCE]  = bd;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      sb.set_reg(i[CFG_IDX_W-1:0], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Targets stay close to the present floor, which keeps the moves short
  // enough to finish many times in a phase.
  function automatic logic [FLOOR_W-1:0] pick_target(int maxd);
    int lo;
    int hi;
    lo = int'(sb.cur_floor) - maxd;
    hi = int'(sb.cur_floor) + maxd;
    if (lo < 0) lo = 0;
    if (hi > 63) hi = 63;
    return FLOOR_W'($urandom_range(hi, lo));
  endfunction

  // One random phase: a fresh setting, then words until n of them have had an
  // effect (a move taken while at rest, or a tick while moving), then a drain.
  // Moves offered while busy and ticks while at rest are the noise here.
  task automatic run_phase(logic [CFG_W-1:0] sp, logic [CFG_W-1:0] tp,
                           logic [CFG_W-1:0] spf, logic [CFG_W-1:0] bd,
                           int n, int maxd, bit quiet);
    int   count;
    bit   busy_before;
    logic cmd;
    set_config(sp, tp, spf, bd);
    count = 0;
    while (count < n) begin
      if (!quiet && $urandom_range(39, 0) == 0) begin
        send_gaps = 1'($urandom_range(1, 0));
        stall_en <= 1'($urandom_range(1, 0));
      end
      busy_before = sb.moving;
      if (busy_before) cmd = ($urandom_range(15, 0) == 0) ? CMD_MOVE : CMD_TICK;
      else cmd = ($urandom_range(2, 0) == 0) ? CMD_TICK : CMD_MOVE;
      send_word(cmd, pick_target(maxd));
      if (busy_before == (cmd == CMD_TICK)) count++;
    end
    drain_move();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run at the reset values first. A tick at rest changes
    // nothing and a move to the present floor finishes on its own word.
    send_word(CMD_TICK, 6'd63);
    send_word(CMD_MOVE, 6'd0);

    // Zero half period, so every phase lasts a single tick, with the lowest
    // steps per floor and no braking: travel to the top floor, where a move
    // offered while busy is dropped without counting as a tick, then a short
    // move down and a move to the floor the lift already stands on.
    set_config(12'd0, 12'd0, 12'd1, 12'd0);
    send_word(CMD_MOVE, 6'd63);
    send_word(CMD_TICK, 6'd21);
    send_word(CMD_MOVE, 6'd5);
    drain_move();
    send_word(CMD_MOVE, 6'd60);
    drain_move();
    send_word(CMD_MOVE, 6'd60);

    // Top speed equal to the start speed: the period cannot fall.
    set_config(12'd3, 12'd3, 12'd2, 12'd0);
    send_word(CMD_MOVE, 6'd61);
    drain_move();

    // A downward move that speeds up first and then brakes.
    set_config(12'd2, 12'd1, 12'd3, 12'd2);
    send_word(CMD_MOVE, 6'd59);
    drain_move();

    // Random phases with small settings; the last one runs without idling.
    send_gaps = 1'b1;
    stall_en <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      if (p == 3) begin
        send_gaps = 1'b0;
        stall_en <= 1'b0;
      end
      run_phase(CFG_W'($urandom_range(6, 0)), CFG_W'($urandom_range(6, 0)),
                CFG_W'($urandom_range(3, 1)), CFG_W'($urandom_range(4, 0)), 70,
                ($urandom_range(1, 0) == 1) ? 4 : 2, p == 3);
    end

    // All words are in; wait for the last results and the pipeline to empty.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
